// ===== src/rtu_pkg.sv =====
// Shared constants, types and helpers for the serial frame receiver.
package rtu_pkg;

    localparam int unsigned DEF_MAX_FRAME_BYTES = 256;
    localparam int unsigned DEF_MIN_FRAME_BYTES = 4;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CRC_W    = 16;
    localparam int unsigned LEN_W    = 9;
    localparam int unsigned REQ_W    = 2;
    localparam int unsigned VERD_W   = 3;
    localparam int unsigned OUT_W    = 32;

    localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;
    localparam logic [BYTE_W-1:0] BCAST_ADDR    = 8'h00;
    localparam logic [BYTE_W-1:0] OWN_ADDR_RST  = 8'h01;

    localparam logic [BYTE_W-1:0] FC_RD_COILS    = 8'h01;
    localparam logic [BYTE_W-1:0] FC_RD_DISCRETE = 8'h02;
    localparam logic [BYTE_W-1:0] FC_RD_HOLDING  = 8'h03;
    localparam logic [BYTE_W-1:0] FC_RD_INPUT    = 8'h04;
    localparam logic [BYTE_W-1:0] FC_RD_WR_MULTI = 8'h17;

    typedef enum logic [REQ_W-1:0] {
        REQ_BYTE    = 2'd0,
        REQ_GAP     = 2'd1,
        REQ_SILENCE = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    typedef enum logic [VERD_W-1:0] {
        V_ACCEPTED      = 3'd0,
        V_OVERFLOW      = 3'd1,
        V_TOO_SHORT     = 3'd2,
        V_ADDR_MISMATCH = 3'd3,
        V_CRC_ERROR     = 3'd4,
        V_BCAST_READ    = 3'd5
    } t_verdict;

    function automatic logic is_read_code(input logic [BYTE_W-1:0] fc);
        is_read_code = (fc == FC_RD_COILS) || (fc == FC_RD_DISCRETE) ||
                       (fc == FC_RD_HOLDING) || (fc == FC_RD_INPUT) ||
                       (fc == FC_RD_WR_MULTI);
    endfunction

endpackage

// ===== src/rtu_crc16.sv =====
// One-byte CRC-16 update, reflected polynomial, eight bit steps.
module rtu_crc16 (
    input  logic [rtu_pkg::CRC_W-1:0]  i_crc,
    input  logic [rtu_pkg::BYTE_W-1:0] i_byte,
    output logic [rtu_pkg::CRC_W-1:0]  o_crc
);
    import rtu_pkg::*;

    always_comb begin
        logic [CRC_W-1:0] c;
        c = i_crc ^ {{(CRC_W-BYTE_W){1'b0}}, i_byte};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

// ===== src/rtu_frame_receiver_checker_top.sv =====
// Serial frame receiver: silence framing, length, address and CRC checks.
//
//  Channel   Ports              Contents (low bit first)
//  in        s_axis_*           tuser: req_type[1:0]; tdata: data_byte[7:0]
//  out       m_axis_*           tdata: verdict[2:0], frame_length[11:3],
//                               dest_address[19:12], function_code[27:20],
//                               is_broadcast[28], zero[31:29]
//  config    i_cfg_we/wdata     own_address[7:0]
//
//  One word per cycle unless held off; the verdict is registered from the silence word.
//  The CRC update feeds the frame state; the checks sit before the output register.
//  Synchronous active-low reset; own address resets to 1.
//  Input is held off only while a verdict waits and the output is stalled.
module rtu_frame_receiver_checker_top #(
    parameter int unsigned MAX_FRAME_BYTES = rtu_pkg::DEF_MAX_FRAME_BYTES,
    parameter int unsigned MIN_FRAME_BYTES = rtu_pkg::DEF_MIN_FRAME_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rtu_pkg::BYTE_W-1:0]    i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [rtu_pkg::BYTE_W-1:0]    s_axis_tdata,  // data_byte
    input  logic [rtu_pkg::REQ_W-1:0]     s_axis_tuser,  // req_type
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [rtu_pkg::OUT_W-1:0]     m_axis_tdata   // verdict, length, addr, fc, bcast
);
    import rtu_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);
    localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_FRAME_BYTES);

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_RX   = 2'd1,
        S_WAIT = 2'd2
    } t_mode;

    t_mode             r_mode, n_mode;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_good, n_good;
    logic [CRC_W-1:0]  r_crc, n_crc;
    logic [BYTE_W-1:0] r_first, n_first;
    logic [BYTE_W-1:0] r_second, n_second;
    logic [BYTE_W-1:0] r_own;
    logic              r_out_valid, n_out_valid;
    logic [OUT_W-1:0]  r_out, n_out;

    logic              accept;
    t_req              req;
    logic [CNT_W-1:0]  b_cnt;
    logic [CRC_W-1:0]  b_crc;
    logic [CRC_W-1:0]  crc_upd;
    t_verdict          verdict;
    logic              bcast;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign req           = t_req'(s_axis_tuser);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    assign b_cnt = (r_mode == S_IDLE) ? '0 : r_cnt;
    assign b_crc = (r_mode == S_IDLE) ? CRC_INIT : r_crc;

    rtu_crc16 u_crc (
        .i_crc  (b_crc),
        .i_byte (s_axis_tdata),
        .o_crc  (crc_upd)
    );

    assign bcast = (r_first == BCAST_ADDR);

    always_comb begin
        if (!r_good) begin
            verdict = V_OVERFLOW;
        end else if (r_cnt < CNT_MIN) begin
            verdict = V_TOO_SHORT;
        end else if (!bcast && (r_first != r_own)) begin
            verdict = V_ADDR_MISMATCH;
        end else if (r_crc != '0) begin
            verdict = V_CRC_ERROR;
        end else if (bcast && is_read_code(r_second)) begin
            verdict = V_BCAST_READ;
        end else begin
            verdict = V_ACCEPTED;
        end
    end

    always_comb begin
        n_mode      = r_mode;
        n_cnt       = r_cnt;
        n_good      = r_good;
        n_crc       = r_crc;
        n_first     = r_first;
        n_second    = r_second;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out       = r_out;
        if (accept) begin
            unique case (req)
                REQ_BYTE: begin
                    if (r_mode == S_IDLE || r_mode == S_RX) begin
                        if (r_mode == S_IDLE) begin
                            n_first  = '0;
                            n_second = '0;
                            n_good   = 1'b1;
                        end
                        n_mode = S_RX;
                        if (b_cnt < CNT_MAX) begin
                            if (b_cnt == CNT_W'(0)) begin
                                n_first = s_axis_tdata;
                            end else if (b_cnt == CNT_W'(1)) begin
                                n_second = s_axis_tdata;
                            end
                            n_crc = crc_upd;
                            n_cnt = b_cnt + CNT_W'(1);
                        end else begin
                            n_good = 1'b0;
                            n_mode = S_WAIT;
                        end
                    end
                end
                REQ_GAP: begin
                    if (r_mode == S_RX) begin
                        n_mode = S_WAIT;
                    end
                end
                REQ_SILENCE: begin
                    if (r_mode == S_WAIT) begin
                        n_mode      = S_IDLE;
                        n_out_valid = 1'b1;
                        n_out       = {3'b000, bcast, r_second, r_first,
                                       LEN_W'(r_cnt), verdict};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= S_IDLE;
            r_cnt       <= '0;
            r_good      <= 1'b1;
            r_crc       <= CRC_INIT;
            r_first     <= '0;
            r_second    <= '0;
            r_own       <= OWN_ADDR_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_cnt       <= n_cnt;
            r_good      <= n_good;
            r_crc       <= n_crc;
            r_first     <= n_first;
            r_second    <= n_second;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_own <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("byte count beyond frame limit");

    a_silence_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && req == REQ_SILENCE && r_mode == S_WAIT)
        |=> (r_mode == S_IDLE && r_out_valid))
        else $error("silence in wait did not give a verdict");

    a_overflow_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out[VERD_W-1:0] == V_OVERFLOW)
        |-> (r_out[VERD_W +: LEN_W] == LEN_W'(MAX_FRAME_BYTES)))
        else $error("overflow verdict without a full frame");

    a_accept_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out[VERD_W-1:0] == V_ACCEPTED)
        |-> (r_out[VERD_W +: LEN_W] >= LEN_W'(MIN_FRAME_BYTES)))
        else $error("short frame accepted");

endmodule

// ===== sim/rtu_frame_receiver_checker_top_test.sv =====
// Serial frame receiver testbench: directed and random traffic against a verdict predictor.
module rtu_frame_receiver_checker_top_test;
    import rtu_pkg::*;

    localparam int unsigned MAX_BYTES = DEF_MAX_FRAME_BYTES;
    localparam int unsigned MIN_BYTES = DEF_MIN_FRAME_BYTES;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [BYTE_W-1:0] READ_CODES [5] = '{FC_RD_COILS, FC_RD_DISCRETE,
        FC_RD_HOLDING, FC_RD_INPUT, FC_RD_WR_MULTI};

    typedef enum logic [1:0] {
        LINK_IDLE,
        LINK_RECEIVING,
        LINK_HOLD
    } t_link_mode;

    typedef struct packed {
        t_verdict          verdict;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] dest;
        logic [BYTE_W-1:0] fc;
        logic              bcast;
    } t_frame_verdict;

    class verdict_tracker;
        t_link_mode        mode = LINK_IDLE;
        int unsigned       count = 0;
        bit                good = 1'b1;
        logic [CRC_W-1:0]  crc = CRC_INIT;
        logic [BYTE_W-1:0] first = '0;
        logic [BYTE_W-1:0] second = '0;
        logic [BYTE_W-1:0] unit_addr = OWN_ADDR_RST;
        t_frame_verdict    pending_verdicts[$];
        int                failures = 0;

        static function logic [CRC_W-1:0] crc_update(logic [CRC_W-1:0] c,
                                                      logic [BYTE_W-1:0] b);
            c = c ^ {8'h00, b};
            for (int i = 0; i < 8; i++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            return c;
        endfunction

        function bit read_request(logic [BYTE_W-1:0] code);
            foreach (READ_CODES[i]) begin
                if (code == READ_CODES[i]) begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void set_address(logic [BYTE_W-1:0] a);
            unit_addr = a;
        endfunction

        function void note_word(t_req req, logic [BYTE_W-1:0] d);
            t_frame_verdict v;
            case (req)
                REQ_BYTE: begin
                    if (mode == LINK_IDLE) begin
                        mode = LINK_RECEIVING;
                        count = 0;
                        good = 1'b1;
                        crc = CRC_INIT;
                        first = '0;
                        second = '0;
                    end
                    if (mode == LINK_RECEIVING) begin
                        if (count < MAX_BYTES) begin
                            if (count == 0) begin
                                first = d;
                            end else if (count == 1) begin
                                second = d;
                            end
                            crc = crc_update(crc, d);
                            count++;
                        end else begin
                            good = 1'b0;
                            mode = LINK_HOLD;
                        end
                    end
                end
                REQ_GAP: begin
                    if (mode == LINK_RECEIVING) begin
                        mode = LINK_HOLD;
                    end
                end
                REQ_SILENCE: begin
                    if (mode == LINK_HOLD) begin
                        if (!good) begin
                            v.verdict = V_OVERFLOW;
                        end else if (count < MIN_BYTES) begin
                            v.verdict = V_TOO_SHORT;
                        end else if (first != BCAST_ADDR && first != unit_addr) begin
                            v.verdict = V_ADDR_MISMATCH;
                        end else if (crc != '0) begin
                            v.verdict = V_CRC_ERROR;
                        end else if (first == BCAST_ADDR && read_request(second)) begin
                            v.verdict = V_BCAST_READ;
                        end else begin
                            v.verdict = V_ACCEPTED;
                        end
                        v.length = LEN_W'(count);
                        v.dest = first;
                        v.fc = second;
                        v.bcast = (first == BCAST_ADDR);
                        pending_verdicts.push_back(v);
                        mode = LINK_IDLE;
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, int unsigned exp, int unsigned act);
            if (exp != act) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
                failures++;
            end
        endfunction

        function void check_verdict(logic [OUT_W-1:0] w);
            t_frame_verdict v;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected verdict word, expected none, got %0h", $time, w);
                failures++;
                return;
            end
            v = pending_verdicts.pop_front();
            compare_field("verdict", v.verdict, w[2:0]);
            compare_field("frame_length", v.length, w[11:3]);
            compare_field("dest_address", v.dest, w[19:12]);
            compare_field("function_code", v.fc, w[27:20]);
            compare_field("is_broadcast", v.bcast, w[28]);
            compare_field("padding", 0, w[31:29]);
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [BYTE_W-1:0] i_cfg_wdata = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [BYTE_W-1:0] s_axis_tdata = '0;
    logic [REQ_W-1:0]  s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;

    verdict_tracker tracker = new();
    bit jitter_on = 1'b1;
    int words_sent = 0;
    int cycles = 0;

    rtu_frame_receiver_checker_top #(
        .MAX_FRAME_BYTES(MAX_BYTES),
        .MIN_FRAME_BYTES(MIN_BYTES)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= !jitter_on || ($urandom_range(99) >= 22);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.check_verdict(m_axis_tdata);
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_word(input t_req req, input logic [BYTE_W-1:0] d);
        while (jitter_on && $urandom_range(99) < 22) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= d;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        tracker.note_word(req, d);
        if (req != REQ_NONE) begin
            words_sent++;
        end
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] addr, input logic [BYTE_W-1:0] fc,
                              input int n_body, input bit with_crc, input bit corrupt,
                              input bit close);
        logic [CRC_W-1:0]  crc;
        logic [BYTE_W-1:0] b;
        crc = CRC_INIT;
        for (int k = 0; k < n_body; k++) begin
            b = (k == 0) ? addr : (k == 1) ? fc : BYTE_W'($urandom);
            crc = verdict_tracker::crc_update(crc, b);
            send_word(REQ_BYTE, b);
        end
        if (with_crc) begin
            if (corrupt) begin
                crc = crc ^ CRC_W'(1 << $urandom_range(15));
            end
            send_word(REQ_BYTE, crc[7:0]);
            send_word(REQ_BYTE, crc[15:8]);
        end
        if (close) begin
            send_word(REQ_GAP, BYTE_W'($urandom));
            send_word(REQ_SILENCE, BYTE_W'($urandom));
        end
    endtask

    // close any open frame and let the last verdict out
    task automatic drain_link();
        send_word(REQ_GAP, 8'h00);
        send_word(REQ_SILENCE, 8'h00);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_verdicts.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_address(input logic [BYTE_W-1:0] a);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= a;
        @(posedge i_clk);
        tracker.set_address(a);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [BYTE_W-1:0] addr, input int n_words,
                             input bit jitter);
        int start;
        int r;
        int n_body;
        logic [BYTE_W-1:0] dest;
        logic [BYTE_W-1:0] fc;
        write_address(addr);
        jitter_on = jitter;
        start = words_sent;
        while (words_sent - start < n_words) begin
            r = $urandom_range(99);
            if (r < 70) begin
                r = $urandom_range(99);
                dest = (r < 45) ? addr : (r < 65) ? BCAST_ADDR : BYTE_W'($urandom);
                fc = ($urandom_range(1) == 1) ? READ_CODES[$urandom_range(4)]
                                              : BYTE_W'($urandom);
                n_body = ($urandom_range(99) < 2) ? $urandom_range(240, 256)
                                                  : $urandom_range(2, 12);
                send_frame(dest, fc, n_body, $urandom_range(99) < 95,
                           $urandom_range(99) < 12, 1'b1);
            end else if (r < 85) begin
                dest = ($urandom_range(1) == 1) ? addr : BYTE_W'($urandom);
                send_frame(dest, BYTE_W'($urandom), $urandom_range(1, 6),
                           1'($urandom_range(1)), 1'($urandom_range(1)),
                           1'($urandom_range(1)));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_word(t_req'($urandom_range(3)), BYTE_W'($urandom));
                end
            end
        end
        drain_link();
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ticks and unknown requests while idle
        send_word(REQ_GAP, 8'hFF);
        send_word(REQ_SILENCE, 8'h00);
        send_word(REQ_NONE, 8'hFF);
        send_frame(8'h01, FC_RD_HOLDING, 6, 1'b1, 1'b0, 1'b1);
        send_frame(BCAST_ADDR, FC_RD_COILS, 6, 1'b1, 1'b0, 1'b1);
        send_frame(BCAST_ADDR, FC_RD_WR_MULTI, 4, 1'b1, 1'b0, 1'b1);
        send_frame(BCAST_ADDR, 8'h06, 6, 1'b1, 1'b0, 1'b1);
        send_frame(8'h01, 8'hFF, 2, 1'b1, 1'b0, 1'b1);
        send_frame(8'h01, 8'h10, 1, 1'b0, 1'b0, 1'b1);
        send_frame(8'h01, 8'h10, 3, 1'b0, 1'b0, 1'b1);
        send_frame(8'hFF, FC_RD_INPUT, 4, 1'b1, 1'b0, 1'b1);
        send_frame(8'h01, FC_RD_DISCRETE, 4, 1'b1, 1'b1, 1'b1);
        // silence mid-frame, bytes and a second gap while waiting for silence
        send_word(REQ_BYTE, 8'h01);
        send_word(REQ_BYTE, 8'h10);
        send_word(REQ_SILENCE, 8'h00);
        send_word(REQ_BYTE, 8'h00);
        send_word(REQ_BYTE, 8'hFF);
        send_word(REQ_NONE, 8'h00);
        send_word(REQ_GAP, 8'h00);
        send_word(REQ_BYTE, 8'h55);
        send_word(REQ_GAP, 8'h00);
        send_word(REQ_SILENCE, 8'hFF);
        // longest legal frame, then one byte too many
        send_frame(8'h01, 8'h10, MAX_BYTES - 2, 1'b1, 1'b0, 1'b1);
        send_frame(8'h01, 8'h10, MAX_BYTES + 1, 1'b0, 1'b0, 1'b0);
        send_word(REQ_BYTE, 8'hAA);
        drain_link();

        run_phase(8'd247, 100, 1'b1);
        run_phase(8'd0, 100, 1'b0);
        run_phase(8'd255, 100, 1'b1);
        run_phase(BYTE_W'($urandom_range(2, 246)), 100, 1'b1);
        run_phase(8'd1, 100, 1'b1);

        repeat (10) @(posedge i_clk);
        if (tracker.failures == 0 && tracker.pending_verdicts.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
src/rtu_pkg.sv
src/rtu_crc16.sv
src/rtu_frame_receiver_checker_top.sv
sim/rtu_frame_receiver_checker_top_test.sv
